// File: rtl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the FIFO free-page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned MaxPages = 1024;
  localparam int unsigned PageW    = 10;
  localparam int unsigned CountW   = 11;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StReserved = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [PageW-1:0] free_page;
  } req_t;

  typedef struct packed {
    logic [PageW-1:0] page;
    logic [1:0]       status;
  } res_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// File: rtl/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Controller: takes a word on start, enters the execute state, then strobes done.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output ffpa_pkg::cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic done_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.execute = 1'b1;
        state_d       = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.execute;
    end
  end

  assign busy   = (state_q == StExec);
  assign done_o = done_q;

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.execute)
    else $error("Capture was not followed by an execute cycle.");

  a_exec_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> done_q && !cmd_o.execute)
    else $error("Execute cycle did not produce exactly one done strobe.");

  a_busy_no_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cmd_o.capture)
    else $error("A word was captured while busy.");

endmodule

// File: rtl/ffpa_datapath.sv
// ----------------------------------------------------------------------------
// ffpa_datapath
// Free-list registers, link memory and result register of the allocator.
// ----------------------------------------------------------------------------
module ffpa_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ffpa_pkg::cmd_t  cmd_i,
  input  ffpa_pkg::req_t  req_i,
  output ffpa_pkg::res_t  res_o
);

  logic [ffpa_pkg::PageW-1:0] link_mem [ffpa_pkg::MaxPages];
  logic [ffpa_pkg::PageW-1:0] link_rd_q;

  ffpa_pkg::req_t              req_q;
  ffpa_pkg::res_t              res_q, res_d;
  logic                        empty_q, empty_d;
  logic [ffpa_pkg::PageW-1:0]  head_q, head_d;
  logic [ffpa_pkg::PageW-1:0]  tail_q, tail_d;
  logic [ffpa_pkg::CountW-1:0] inuse_q, inuse_d;
  logic                        link_we;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= req_i;
      link_rd_q <= link_mem[head_q];
    end
    if (link_we) begin
      link_mem[tail_q] <= req_q.free_page;
    end
    if (cmd_i.execute) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    empty_d      = empty_q;
    head_d       = head_q;
    tail_d       = tail_q;
    inuse_d      = inuse_q;
    link_we      = 1'b0;
    res_d.page   = '0;
    res_d.status = ffpa_pkg::StOk;
    if (cmd_i.execute) begin
      if (req_q.operation == ffpa_pkg::OpAlloc) begin
        priority if (!empty_q) begin
          res_d.page = head_q;
          if (head_q == tail_q) begin
            empty_d = 1'b1;
            head_d  = '0;
            tail_d  = '0;
          end else begin
            head_d = link_rd_q;
          end
        end else if (inuse_q >= ffpa_pkg::CountW'(ffpa_pkg::MaxPages)) begin
          res_d.status = ffpa_pkg::StFull;
        end else begin
          res_d.page = inuse_q[ffpa_pkg::PageW-1:0];
          inuse_d    = inuse_q + ffpa_pkg::CountW'(1);
        end
      end else begin
        priority if (req_q.free_page == '0) begin
          res_d.status = ffpa_pkg::StReserved;
        end else if (empty_q) begin
          empty_d = 1'b0;
          head_d  = req_q.free_page;
          tail_d  = req_q.free_page;
        end else begin
          link_we = 1'b1;
          tail_d  = req_q.free_page;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
      head_q  <= '0;
      tail_q  <= '0;
      inuse_q <= ffpa_pkg::CountW'(1);
    end else begin
      empty_q <= empty_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      inuse_q <= inuse_d;
    end
  end

  assign res_o = res_q;

  a_empty_clears_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0) && (tail_q == '0))
    else $error("Empty free list with nonzero head or tail.");

  a_inuse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inuse_q >= ffpa_pkg::CountW'(1)) &&
    (inuse_q <= ffpa_pkg::CountW'(ffpa_pkg::MaxPages)))
    else $error("Page count outside its range.");

  a_refusal_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.execute) && (res_q.status != ffpa_pkg::StOk) |-> res_q.page == '0)
    else $error("Refused request returned a nonzero page.");

endmodule

// File: rtl/fifo_free_page_allocator.sv
// ----------------------------------------------------------------------------
// fifo_free_page_allocator
// Page allocator with a FIFO free list kept as a linked list in a memory.
// ----------------------------------------------------------------------------
// A request word is taken on req_i at a clock edge where start is high and
// busy is low. An allocate returns the head of the free list, or a fresh
// page while pages remain, or store full. A free appends the page at the
// tail of the list; freeing page 0 is refused.
// A request is handled in an accept cycle, which reads the head's link word
// from the link memory, and a following cycle, with busy high, that updates the
// list and registers the result. The result word then appears on res_o, marked
// by done_o for one cycle, and stays there until the next result; a new request
// may be accepted while done_o is high, so requests do not overlap.
// The link memory is read in the accept cycle, before the head update.
// The receiver cannot hold results off; each one is accepted as it appears.
// Reset empties the free list and counts only the reserved page in use. The
// link memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module fifo_free_page_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ffpa_pkg::req_t  req_i,
  output logic           done_o,
  output ffpa_pkg::res_t  res_o
);

  ffpa_pkg::cmd_t cmd;

  ffpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  ffpa_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .res_o  (res_o)
  );

endmodule

// File: dv/fifo_free_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_free_page_allocator_tb
// Self-checking testbench for the FIFO free-page allocator.
// ----------------------------------------------------------------------------
// A driver feeds allocate and free words from a pending queue. Idle gaps of
// random length are inserted on the request side. A monitor keeps a copy of
// the free list, the link words and the count of pages in use. For every
// accepted word it predicts the result and compares each returned word with
// the oldest prediction. The run starts with a short directed part. Random
// parts then free mostly pages handed out earlier. A last stretch runs
// without idle gaps.
// ----------------------------------------------------------------------------
module fifo_free_page_allocator_tb;

  localparam int unsigned LimitNs = 5_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  ffpa_pkg::req_t req_i = '0;
  logic done_o;
  ffpa_pkg::res_t res_o;

  ffpa_pkg::req_t             pending_words[$];
  ffpa_pkg::res_t             expected_res[$];
  logic [ffpa_pkg::PageW-1:0] owned_pages[$];

  logic                        fl_empty = 1'b1;
  logic [ffpa_pkg::PageW-1:0]  fl_head  = '0;
  logic [ffpa_pkg::PageW-1:0]  fl_tail  = '0;
  logic [ffpa_pkg::CountW-1:0] used_pages = ffpa_pkg::CountW'(1);
  logic [ffpa_pkg::PageW-1:0]  link_mem [ffpa_pkg::MaxPages];

  bit gaps_on    = 1'b1;
  bit word_taken = 1'b0;
  int gap_left   = 0;
  int n_queued   = 0;
  int n_taken    = 0;
  int n_done     = 0;
  int n_errors   = 0;
  int n_full     = 0;
  int n_reserved = 0;

  fifo_free_page_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic ffpa_pkg::res_t apply_page_request(ffpa_pkg::req_t w);
    ffpa_pkg::res_t r;
    r.page   = '0;
    r.status = ffpa_pkg::StOk;
    if (w.operation == ffpa_pkg::OpAlloc) begin
      if (!fl_empty) begin
        r.page = fl_head;
        if (fl_head == fl_tail) begin
          fl_empty = 1'b1;
          fl_head  = '0;
          fl_tail  = '0;
        end else begin
          fl_head = link_mem[fl_head];
        end
      end else if (used_pages >= ffpa_pkg::MaxPages) begin
        r.status = ffpa_pkg::StFull;
      end else begin
        r.page     = used_pages[ffpa_pkg::PageW-1:0];
        used_pages = used_pages + 1'b1;
      end
    end else begin
      if (w.free_page == '0) begin
        r.status = ffpa_pkg::StReserved;
      end else if (fl_empty) begin
        fl_empty = 1'b0;
        fl_head  = w.free_page;
        fl_tail  = w.free_page;
      end else begin
        link_mem[fl_tail] = w.free_page;
        fl_tail           = w.free_page;
      end
    end
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && !(start && !word_taken)) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        gap_left = $urandom_range(0, 10);
      end else begin
        start <= 1'b1;
        req_i <= pending_words.pop_front();
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    ffpa_pkg::res_t exp_r;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_res.size() == 0) begin
          $error("result word with none expected: page %0d status %0d",
                 res_o.page, res_o.status);
          n_errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (res_o.page !== exp_r.page) begin
            $error("page: expected %0d, actual %0d", exp_r.page, res_o.page);
            n_errors++;
          end
          if (res_o.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, res_o.status);
            n_errors++;
          end
          n_done++;
        end
      end
      if (start && busy === 1'b0) begin
        exp_r = apply_page_request(req_i);
        expected_res.push_back(exp_r);
        if (req_i.operation == ffpa_pkg::OpAlloc && exp_r.status == ffpa_pkg::StOk) begin
          owned_pages.push_back(exp_r.page);
        end
        if (exp_r.status == ffpa_pkg::StFull) n_full++;
        if (exp_r.status == ffpa_pkg::StReserved) n_reserved++;
        word_taken = 1'b1;
        n_taken++;
      end
    end
  end

  task automatic queue_word(logic op, logic [ffpa_pkg::PageW-1:0] idx);
    ffpa_pkg::req_t w;
    w.operation = op;
    w.free_page = idx;
    while (pending_words.size() >= 4) @(posedge clk_i);
    pending_words.push_back(w);
    n_queued++;
  endtask

  task automatic queue_random_word(int alloc_pct);
    int                         pick;
    logic [ffpa_pkg::PageW-1:0] idx;
    if ($urandom_range(0, 99) < alloc_pct) begin
      queue_word(ffpa_pkg::OpAlloc, ffpa_pkg::PageW'($urandom));
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        idx = '0;
      end else if (pick <= 2 || owned_pages.size() == 0) begin
        idx = ffpa_pkg::PageW'($urandom);
      end else begin
        pick = $urandom_range(0, owned_pages.size() - 1);
        idx  = owned_pages[pick];
        owned_pages.delete(pick);
      end
      queue_word(ffpa_pkg::OpFree, idx);
    end
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || expected_res.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_word(ffpa_pkg::OpFree, 10'd0);
    queue_word(ffpa_pkg::OpAlloc, 10'd1023);
    queue_word(ffpa_pkg::OpAlloc, 10'd0);
    queue_word(ffpa_pkg::OpAlloc, 10'd0);
    queue_word(ffpa_pkg::OpFree, 10'd1023);
    queue_word(ffpa_pkg::OpFree, 10'd2);
    queue_word(ffpa_pkg::OpFree, 10'd1);
    queue_word(ffpa_pkg::OpAlloc, 10'd0);
    queue_word(ffpa_pkg::OpAlloc, 10'd0);
    queue_word(ffpa_pkg::OpAlloc, 10'd0);
    queue_word(ffpa_pkg::OpAlloc, 10'd0);
    queue_word(ffpa_pkg::OpFree, 10'd3);
    queue_word(ffpa_pkg::OpFree, 10'd3);
    queue_word(ffpa_pkg::OpAlloc, 10'd0);
    queue_word(ffpa_pkg::OpAlloc, 10'd0);
    queue_word(ffpa_pkg::OpFree, 10'd682);
    queue_word(ffpa_pkg::OpFree, 10'd341);
    queue_word(ffpa_pkg::OpAlloc, 10'd682);
    queue_word(ffpa_pkg::OpAlloc, 10'd341);
    wait_drained();

    for (int i = 0; i < 300; i++) begin
      if (i % 60 == 0) gaps_on = (i % 120 == 0);
      queue_random_word(55);
    end
    gaps_on = 1'b1;

    for (int i = 0; i < 200; i++) queue_random_word(45);
    wait_drained();

    gaps_on = 1'b0;
    for (int i = 0; i < 150; i++) queue_random_word(50);
    wait_drained();

    $display("Ran %0d request words through directed, random reuse and gap-free phases;",
             n_taken);
    $display("checked %0d results, %0d of them store full and %0d page 0 refusals.",
             n_done, n_full, n_reserved);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
